@@ hw/rtl/ttn_pkg.sv @@
`default_nettype none
package ttn_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned MAX_LENGTH_W    = 16;
  localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RST = 16'hFFFF;
  localparam int unsigned MIN_LIMIT       = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_AMP) || (c == CH_DASH) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_SLASH) ||
           (c == CH_COMMA) || (c == CH_DOT) || (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ttn_if.sv @@
`default_nettype none
interface ttn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       row_is_null;

  modport source (output valid, in_byte, row_is_null, input ready);
  modport sink   (input valid, in_byte, row_is_null, output ready);
endinterface

interface ttn_out_if #(
  parameter int unsigned LENGTH_BITS = ttn_pkg::LENGTH_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 end_of_string;
  logic [LENGTH_BITS:0] out_length;
  logic                 not_null;
  logic                 some_empty;

  modport source (output valid, out_byte, end_of_string, out_length, not_null,
                  some_empty, input ready);
  modport sink   (input valid, out_byte, end_of_string, out_length, not_null,
                  some_empty, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/title_text_normalizer.sv @@
`default_nettype none
// Channel   Dir  Payload                                            Words
// items     in   in_byte[7:0], row_is_null                          one byte per word
// results   out  out_byte[7:0], end_of_string, out_length[LB:0],    zero or one per item
//                not_null, some_empty
// cfg       in   cfg_wr_en, cfg_wr_data[15:0] (max_length)          single register
//
// Throughput: one input word per cycle while no held result stalls the input.
// Path: an accepted input word goes through the input register, then the result
//   register, to its result word; dropped bytes give nothing.
// Reset (rst, sync): clears valids, spacing/count state and the sticky empty
//   flag; max_length returns to 65535, the largest setting.
// Stalls: a held result keeps the input register full; items.ready then drops,
//   so at most one word waits on each side.
module title_text_normalizer #(
  parameter int unsigned LENGTH_BITS = ttn_pkg::LENGTH_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  ttn_in_if.sink                           items,
  ttn_out_if.source                        results,
  input  wire                              cfg_wr_en,
  input  wire [ttn_pkg::MAX_LENGTH_W-1:0]  cfg_wr_data
);
  import ttn_pkg::*;

  // comparison width wide enough for both the register and the count cap
  localparam int unsigned CMP_W = (LENGTH_BITS > MAX_LENGTH_W) ? LENGTH_BITS : MAX_LENGTH_W;

  // config register
  logic [MAX_LENGTH_W-1:0] max_length;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_null;

  // string state
  logic                   last_kept_space, last_kept_space_next;
  logic [LENGTH_BITS-1:0] kept_count, kept_count_next;
  logic                   empty_seen, empty_seen_next;

  // result register
  logic                 o_valid;
  logic [7:0]           o_byte, o_byte_next;
  logic                 o_eos, o_eos_next;
  logic [LENGTH_BITS:0] o_length, o_length_next;
  logic                 o_not_null, o_not_null_next;
  logic                 o_empty;
  logic                 emit;

  logic out_free, s1_adv;
  logic [CMP_W-1:0] ml_ext, cap_ext, lim_ext;
  logic [LENGTH_BITS-1:0] lim;
  logic full;

  // handshake: stage 1 moves on whenever the result register can take a word
  assign out_free      = !o_valid || results.ready;
  assign s1_adv        = s1_valid && out_free;
  assign items.ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_length <= cfg_wr_data;
    end
  end

  // effective limit: clamp to at least two, at most the counter's range
  always_comb begin
    ml_ext  = CMP_W'(max_length);
    cap_ext = CMP_W'({LENGTH_BITS{1'b1}});
    lim_ext = (ml_ext < CMP_W'(MIN_LIMIT)) ? CMP_W'(MIN_LIMIT) : ml_ext;
    if (lim_ext > cap_ext) begin
      lim_ext = cap_ext;
    end
    lim = lim_ext[LENGTH_BITS-1:0];
  end

  assign full = (kept_count >= lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_byte <= items.in_byte;
      s1_null <= items.row_is_null;
    end
  end

  // one byte of normalizing: classify, update spacing state, maybe emit
  always_comb begin
    last_kept_space_next = last_kept_space;
    kept_count_next      = kept_count;
    empty_seen_next      = empty_seen;
    emit                 = 1'b0;
    o_byte_next          = CH_NUL;
    o_eos_next           = 1'b0;
    o_length_next        = '0;
    o_not_null_next      = 1'b0;

    priority if (s1_null) begin
      // null row leaves any string in progress alone
      emit            = 1'b1;
      o_eos_next      = 1'b1;
      o_length_next   = (LENGTH_BITS+1)'(1);
    end else if (s1_byte == CH_NUL) begin
      emit                 = 1'b1;
      o_eos_next           = 1'b1;
      o_not_null_next      = 1'b1;
      o_length_next        = {1'b0, kept_count} + (LENGTH_BITS+1)'(1);
      empty_seen_next      = empty_seen || (kept_count == '0);
      kept_count_next      = '0;
      last_kept_space_next = 1'b0;
    end else if (is_letter(s1_byte)) begin
      last_kept_space_next = 1'b0;
      o_byte_next          = s1_byte | CASE_BIT;
      emit                 = !full;
    end else if (is_ws(s1_byte)) begin
      // leading whitespace only arms the space flag
      last_kept_space_next = 1'b1;
      o_byte_next          = CH_SPACE;
      emit                 = !last_kept_space && (kept_count != '0) && !full;
    end else if (is_punct(s1_byte)) begin
      last_kept_space_next = 1'b1;
      o_byte_next          = CH_SPACE;
      emit                 = !last_kept_space && !full;
    end else begin
      emit = 1'b0;
    end

    if (emit && !o_eos_next) begin
      kept_count_next = kept_count + LENGTH_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_kept_space <= 1'b0;
      kept_count      <= '0;
      empty_seen      <= 1'b0;
    end else if (s1_adv) begin
      last_kept_space <= last_kept_space_next;
      kept_count      <= kept_count_next;
      empty_seen      <= empty_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s1_adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      o_byte     <= o_byte_next;
      o_eos      <= o_eos_next;
      o_length   <= o_length_next;
      o_not_null <= o_not_null_next;
      o_empty    <= empty_seen_next;
    end
  end

  assign results.valid         = o_valid;
  assign results.out_byte      = o_byte;
  assign results.end_of_string = o_eos;
  assign results.out_length    = o_length;
  assign results.not_null      = o_not_null;
  assign results.some_empty    = o_empty;

endmodule
`default_nettype wire

@@ hw/rtl/ttn_checker.sv @@
`default_nettype none
module ttn_checker #(
  parameter int unsigned LENGTH_BITS = ttn_pkg::LENGTH_BITS_DEF
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [7:0]             out_byte,
  input wire                   end_of_string,
  input wire [LENGTH_BITS:0]   out_length,
  input wire                   not_null,
  input wire                   some_empty
);
  import ttn_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(end_of_string) && $stable(out_length) && $stable(not_null))
    else $error("result word changed while stalled");

  // character words are lowercase letters or a single space
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_string |-> (out_byte == CH_SPACE ||
      (out_byte >= CH_LC_A && out_byte <= CH_LC_Z)) && out_length == '0 && !not_null)
    else $error("bad character word");

  // null row closes with length one and terminator byte
  a_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string && !not_null |-> out_length == (LENGTH_BITS+1)'(1) &&
      out_byte == CH_NUL)
    else $error("bad null row word");

  // empty flag never clears once shown
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && some_empty ##1 out_valid |-> some_empty)
    else $error("some_empty dropped");

endmodule

bind title_text_normalizer ttn_checker #(.LENGTH_BITS(LENGTH_BITS)) u_ttn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_byte     (results.out_byte),
  .end_of_string(results.end_of_string),
  .out_length   (results.out_length),
  .not_null     (results.not_null),
  .some_empty   (results.some_empty)
);
`default_nettype wire
